// ===== design/conv3x3_clamp_filter_unit_assert.svh =====
// assertion macros for the 3x3 filter unit
`ifndef CONV3X3_CLAMP_FILTER_UNIT_ASSERT_SVH
`define CONV3X3_CLAMP_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, off while in reset
`define C3CF_ASSERT_IMP(NAME, CK, RS, ANTE, CONS, MSG) \
  NAME: assert property (@(posedge CK) disable iff (RS) (ANTE) |-> (CONS)) \
    else $error(MSG);

// next-cycle implication, off while in reset
`define C3CF_ASSERT_NXT(NAME, CK, RS, ANTE, CONS, MSG) \
  NAME: assert property (@(posedge CK) disable iff (RS) (ANTE) |=> (CONS)) \
    else $error(MSG);

// state seen on the cycle after reset
`define C3CF_ASSERT_RST(NAME, CK, RS, CONS, MSG) \
  NAME: assert property (@(posedge CK) (RS) |=> (CONS)) \
    else $error(MSG);

`endif

// ===== design/c3cf_pkg.sv =====
`default_nettype none

package c3cf_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned KROW_W      = 24;
  localparam int unsigned HEIGHT_W    = 11;
  localparam int unsigned WIDTH_W     = 16;
  localparam int unsigned COL_W       = WIDTH_W + 1;

  localparam logic [PIX_W-1:0]    PIX_MAX        = 8'd255;
  localparam logic [KROW_W-1:0]   KROW_MID_RESET = 24'h010000;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 11'd1024;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET    = 16'd1024;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KERNEL_TOP = 3'd0,
    REG_KERNEL_MID = 3'd1,
    REG_KERNEL_BOT = 3'd2,
    REG_HEIGHT     = 3'd3,
    REG_WIDTH      = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_SHIFT     = 2'd0,
    OP_EMIT      = 2'd1,
    OP_EMIT_LAST = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  typedef struct packed {
    logic [KROW_W-1:0]   kernel_top;
    logic [KROW_W-1:0]   kernel_mid;
    logic [KROW_W-1:0]   kernel_bot;
    logic [HEIGHT_W-1:0] height;
    logic [WIDTH_W-1:0]  width;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic             interior;
    logic [PIX_W-1:0] pixel;
  } item_t;

endpackage

`default_nettype wire

// ===== design/c3cf_ifs.sv =====
`default_nettype none

interface c3cf_pix_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [c3cf_pkg::PIX_W-1:0]   pixel_in;
  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink (input valid, input cmd, input pixel_in, output ready);
endinterface

interface c3cf_res_if;
  logic                         valid;
  logic                         ready;
  logic [c3cf_pkg::PIX_W-1:0]   pixel_out;
  logic                         frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface c3cf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [c3cf_pkg::CFG_INDEX_W-1:0]   index;
  logic [c3cf_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/c3cf_queue.sv =====
`default_nettype none

module c3cf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== design/c3cf_front.sv =====
`default_nettype none

module c3cf_front #(
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  c3cf_pix_if.sink                      pix,
  input  c3cf_pkg::cfg_t                cfg,
  input  logic                          q_full,
  output logic                          push,
  output c3cf_pkg::item_t               item,
  output logic [$clog2(MAX_HEIGHT)-1:0] addr
);

  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned XW = $clog2(MAX_HEIGHT + 2) + 1;
  localparam int unsigned EW = (XW > c3cf_pkg::HEIGHT_W) ? XW : c3cf_pkg::HEIGHT_W;
  localparam int unsigned CW = c3cf_pkg::COL_W;

  logic [RW-1:0] row;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  logic [XW-1:0] pending;
  logic [XW-1:0] pending_next;

  logic [EW-1:0] h_raw;
  logic [XW-1:0] h_eff;
  logic [CW-1:0] w_eff;
  logic [XW-1:0] row_x;
  logic          accept;
  logic          done;
  logic          emit;
  logic          wrap;
  logic          interior;
  logic          advance;
  logic          restart;

  assign pix.ready = !q_full;
  assign accept    = pix.valid && !q_full;
  assign addr      = row;

  always_comb begin
    h_raw = EW'(cfg.height);
    if (cfg.height == '0) begin
      h_eff = XW'(1);
    end else if (h_raw > EW'(MAX_HEIGHT)) begin
      h_eff = XW'(MAX_HEIGHT);
    end else begin
      h_eff = XW'(h_raw);
    end
    w_eff    = (cfg.width == '0) ? CW'(1) : CW'(cfg.width);
    row_x    = XW'(row);
    done     = (col >= w_eff);
    emit     = (pending >= h_eff + XW'(1));
    wrap     = (row_x + XW'(1) >= h_eff);
    interior = (row_x >= XW'(2)) && (col >= CW'(2)) && (col < w_eff) && (row_x < h_eff);
  end

  always_comb begin
    row_next      = row;
    col_next      = col;
    pending_next  = pending;
    push          = 1'b0;
    advance       = 1'b0;
    restart       = 1'b0;
    item.op       = c3cf_pkg::OP_SHIFT;
    item.interior = interior;
    item.pixel    = pix.pixel_in;
    if (accept) begin
      if (!done) begin
        if (pix.cmd == c3cf_pkg::CMD_PUSH) begin
          push    = 1'b1;
          advance = 1'b1;
          if (emit) begin
            item.op = c3cf_pkg::OP_EMIT;
          end else begin
            pending_next = pending + XW'(1);
          end
        end
      end else if (pending == '0) begin
        push    = 1'b1;
        restart = 1'b1;
        item.op = c3cf_pkg::OP_CLEAR;
      end else begin
        push       = 1'b1;
        advance    = 1'b1;
        item.pixel = '0;
        if (pending == XW'(1)) begin
          item.op = c3cf_pkg::OP_EMIT_LAST;
          restart = 1'b1;
        end else begin
          item.op      = c3cf_pkg::OP_EMIT;
          pending_next = pending - XW'(1);
        end
      end
    end
    if (advance) begin
      if (wrap) begin
        row_next = '0;
        col_next = col + CW'(1);
      end else begin
        row_next = row + RW'(1);
      end
    end
    if (restart) begin
      row_next     = '0;
      col_next     = '0;
      pending_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      col     <= '0;
      pending <= '0;
    end else begin
      row     <= row_next;
      col     <= col_next;
      pending <= pending_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/c3cf_back.sv =====
`default_nettype none

module c3cf_back #(
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  c3cf_pkg::cfg_t                cfg,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  c3cf_pkg::item_t               q_item,
  input  logic [$clog2(MAX_HEIGHT)-1:0] q_addr,
  c3cf_res_if.source                    res
);

  localparam int unsigned RW      = $clog2(MAX_HEIGHT);
  localparam int unsigned PW      = c3cf_pkg::PIX_W;
  localparam int unsigned KW      = c3cf_pkg::KROW_W;
  localparam int unsigned ENTRY_W = 2 * PW;
  localparam int unsigned PROD_W  = 2 * PW + 1;
  localparam int unsigned SUM_W   = PROD_W + 4;

  function automatic logic signed [PROD_W-1:0] kernel_weight(
    input logic [KW-1:0] krow,
    input logic [1:0]    sel
  );
    logic [PW-1:0] b;
    b = krow[sel*PW +: PW];
    return {{(PROD_W - PW){b[PW-1]}}, b};
  endfunction

  function automatic logic [PW-1:0] clamp_pixel(input logic [SUM_W-1:0] s);
    logic [PW-1:0] r;
    if (s[SUM_W-1]) begin
      r = '0;
    end else if (s[SUM_W-2:PW] != '0) begin
      r = c3cf_pkg::PIX_MAX;
    end else begin
      r = s[PW-1:0];
    end
    return r;
  endfunction

  // column stores: older column in the high byte, previous column in the low byte
  logic [ENTRY_W-1:0]       cols [MAX_HEIGHT];
  logic [ENTRY_W-1:0]       rd_entry;

  logic                     en;
  logic                     s1_valid;
  c3cf_pkg::item_t          s1_item;
  logic [RW-1:0]            s1_addr;
  logic                     s1_byp;
  logic [ENTRY_W-1:0]       s1_byp_entry;
  logic [ENTRY_W-1:0]       cur_entry;
  logic [ENTRY_W-1:0]       wr_entry;
  logic                     s1_writes;

  logic [PW-1:0]            win [3][3];
  logic [PW-1:0]            win_next [3][3];
  logic [PW-1:0]            shifted [3][3];

  logic                     s2_valid;
  logic                     s2_last;
  logic                     s2_interior;
  logic [PW-1:0]            s2_win [3][3];

  logic [KW-1:0]            krows [3];
  logic signed [PROD_W-1:0] prod [3][3];
  logic                     s3_valid;
  logic                     s3_last;
  logic                     s3_interior;
  logic [PW-1:0]            s3_center;
  logic signed [PROD_W-1:0] s3_prod [3][3];

  logic [SUM_W-1:0]         sum;
  logic                     out_valid;
  logic [PW-1:0]            out_pixel;
  logic                     out_last;

  assign en    = !out_valid || res.ready;
  assign q_pop = en && !q_empty;

  assign res.valid      = out_valid;
  assign res.pixel_out  = out_pixel;
  assign res.frame_last = out_last;

  assign cur_entry = s1_byp ? s1_byp_entry : rd_entry;
  assign wr_entry  = {cur_entry[PW-1:0], s1_item.pixel};
  assign s1_writes = s1_valid && (s1_item.op != c3cf_pkg::OP_CLEAR);

  assign krows[0] = cfg.kernel_top;
  assign krows[1] = cfg.kernel_mid;
  assign krows[2] = cfg.kernel_bot;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      shifted[0][j] = win[1][j];
      shifted[1][j] = win[2][j];
    end
    shifted[2][0] = cur_entry[ENTRY_W-1:PW];
    shifted[2][1] = cur_entry[PW-1:0];
    shifted[2][2] = s1_item.pixel;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win_next[i][j] = win[i][j];
        if (s1_valid) begin
          case (s1_item.op) inside
            c3cf_pkg::OP_CLEAR, c3cf_pkg::OP_EMIT_LAST: win_next[i][j] = '0;
            default:                                    win_next[i][j] = shifted[i][j];
          endcase
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] = $signed({{(PROD_W - PW){1'b0}}, s2_win[i][j]})
                   * kernel_weight(krows[i], 2'(j));
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum = sum + {{(SUM_W - PROD_W){s3_prod[i][j][PROD_W-1]}}, s3_prod[i][j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_writes) begin
      cols[s1_addr] <= wr_entry;
    end
    if (en) begin
      rd_entry <= cols[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (en) begin
      s1_valid  <= !q_empty;
      s2_valid  <= s1_valid && ((s1_item.op == c3cf_pkg::OP_EMIT) ||
                                (s1_item.op == c3cf_pkg::OP_EMIT_LAST));
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
      win       <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item      <= q_item;
      s1_addr      <= q_addr;
      s1_byp       <= s1_writes && (s1_addr == q_addr);
      s1_byp_entry <= wr_entry;
      s2_win       <= shifted;
      s2_last      <= (s1_item.op == c3cf_pkg::OP_EMIT_LAST);
      s2_interior  <= s1_item.interior;
      s3_prod      <= prod;
      s3_center    <= s2_win[1][1];
      s3_last      <= s2_last;
      s3_interior  <= s2_interior;
      out_pixel    <= s3_interior ? clamp_pixel(sum) : s3_center;
      out_last     <= s3_last;
    end
  end

endmodule

`default_nettype wire

// ===== design/conv3x3_clamp_filter_unit.sv =====
// 3x3 convolution filter with clamping, one frame streamed column by column.
// pixel_chan takes requests: cmd push carries a pixel, cmd drain releases one
// pending result once the frame's last pixel is in (a push then does too).
// result_chan returns the filtered pixels in stream order, frame_last marking the final one.
// cfg_chan writes the kernel rows, height and width; always ready. The user
// must write it between frames or while no request is in flight; the block does not enforce this.
// The result for pixel n is released by request n+height+1 and reaches result_chan
// through the queue and the s1, s2, s3 and output registers; the last results, up to
// height+1 of them, come out on the requests that follow the frame's last pixel.
// Throughput is one request per cycle while result_chan is not stalled, set by
// the column store, which takes one read and one write per request.
// A four-entry queue sits between the request decoder and the datapath, so
// requests keep flowing while result_chan is stalled until the queue is full; then
// pixel_chan.ready drops until results are taken again.
// Reset restores the default kernel (weight 1 on the middle row's newest column),
// height 1024, width 1024 and clears the frame counters and window; the column stores are not cleared.
`default_nettype none

module conv3x3_clamp_filter_unit #(
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic       clk,
  input  logic       rst,
  c3cf_pix_if.sink   pixel_chan,
  c3cf_res_if.source result_chan,
  c3cf_cfg_if.sink   cfg_chan
);

  localparam int unsigned RW          = $clog2(MAX_HEIGHT);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned ITEM_W      = $bits(c3cf_pkg::item_t) + RW;

  c3cf_pkg::cfg_t  cfg;
  logic            f_push;
  c3cf_pkg::item_t f_item;
  logic [RW-1:0]   f_addr;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic [ITEM_W-1:0] q_data;
  c3cf_pkg::item_t q_item;
  logic [RW-1:0]   q_addr;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel_top <= '0;
      cfg.kernel_mid <= c3cf_pkg::KROW_MID_RESET;
      cfg.kernel_bot <= '0;
      cfg.height     <= c3cf_pkg::HEIGHT_RESET;
      cfg.width      <= c3cf_pkg::WIDTH_RESET;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        c3cf_pkg::REG_KERNEL_TOP: cfg.kernel_top <= cfg_chan.data[c3cf_pkg::KROW_W-1:0];
        c3cf_pkg::REG_KERNEL_MID: cfg.kernel_mid <= cfg_chan.data[c3cf_pkg::KROW_W-1:0];
        c3cf_pkg::REG_KERNEL_BOT: cfg.kernel_bot <= cfg_chan.data[c3cf_pkg::KROW_W-1:0];
        c3cf_pkg::REG_HEIGHT:     cfg.height     <= cfg_chan.data[c3cf_pkg::HEIGHT_W-1:0];
        c3cf_pkg::REG_WIDTH:      cfg.width      <= cfg_chan.data[c3cf_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  c3cf_front #(
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .pix    (pixel_chan),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (f_push),
    .item   (f_item),
    .addr   (f_addr)
  );

  c3cf_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_item, f_addr}),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  assign {q_item, q_addr} = q_data;

  c3cf_back #(
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .q_addr  (q_addr),
    .res     (result_chan)
  );

endmodule

`default_nettype wire

// ===== design/c3cf_checker.sv =====
`default_nettype none

`include "conv3x3_clamp_filter_unit_assert.svh"

module c3cf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [c3cf_pkg::PIX_W-1:0] pixel_out,
  input logic                       frame_last,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);

  logic                     stall;
  logic [c3cf_pkg::PIX_W:0] res_word;

  assign stall    = out_valid && !out_ready;
  assign res_word = {pixel_out, frame_last};

  // register writes are never held off
  `C3CF_ASSERT_IMP(a_cfg_taken, clk, rst, cfg_valid, cfg_ready, "config write not taken")

  // reset empties the queue and the output stage
  `C3CF_ASSERT_RST(a_reset_empty, clk, rst, in_ready && !out_valid, "not empty after reset")

  `C3CF_ASSERT_NXT(a_out_hold, clk, rst, stall, out_valid, "result dropped")

  `C3CF_ASSERT_NXT(a_out_stable, clk, rst, stall, $stable(res_word), "stalled result changed")

endmodule

bind conv3x3_clamp_filter_unit c3cf_checker u_c3cf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pixel_chan.ready),
  .out_valid  (result_chan.valid),
  .out_ready  (result_chan.ready),
  .pixel_out  (result_chan.pixel_out),
  .frame_last (result_chan.frame_last),
  .cfg_valid  (cfg_chan.valid),
  .cfg_ready  (cfg_chan.ready)
);

`default_nettype wire

// ===== dv/tb.sv =====
module tb;

  localparam int unsigned MAX_ROWS      = 1024;
  localparam int unsigned RANDOM_ITEMS  = 900;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 1000;

  typedef struct packed {
    logic                       cmd;
    logic [c3cf_pkg::PIX_W-1:0] pixel;
  } request_t;

  typedef struct packed {
    logic [c3cf_pkg::PIX_W-1:0] pixel;
    logic                       last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  c3cf_pix_if pix_if ();
  c3cf_res_if res_if ();
  c3cf_cfg_if cfg_if ();

  conv3x3_clamp_filter_unit #(.MAX_HEIGHT(MAX_ROWS)) dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_chan  (pix_if),
    .result_chan (res_if),
    .cfg_chan    (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t request_q [$];
  result_t  filtered_q [$];
  request_t next_req;
  result_t  want_res;

  // filter state mirrored from the block
  logic [c3cf_pkg::PIX_W-1:0]    older_col [0:MAX_ROWS-1];
  logic [c3cf_pkg::PIX_W-1:0]    prev_col [0:MAX_ROWS-1];
  logic [c3cf_pkg::PIX_W-1:0]    win [0:2][0:2];
  logic [c3cf_pkg::KROW_W-1:0]   krow [0:2];
  logic [c3cf_pkg::HEIGHT_W-1:0] height_reg;
  logic [c3cf_pkg::WIDTH_W-1:0]  width_reg;
  int unsigned                   row_pos;
  int unsigned                   col_pos;
  int unsigned                   backlog;

  int unsigned mismatches;
  int unsigned stream_items;
  int unsigned feed_gap;
  int unsigned take_hold;
  int unsigned quiet_cycles;
  bit          feed_calm;
  bit          take_calm;

  function automatic int unsigned eff_rows();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_ROWS) return MAX_ROWS;
    return height_reg;
  endfunction

  function automatic int unsigned eff_cols();
    return (width_reg == 0) ? 1 : width_reg;
  endfunction

  function automatic void restart_frame_state();
    int i;
    int j;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        win[i][j] = '0;
    row_pos = 0;
    col_pos = 0;
    backlog = 0;
  endfunction

  function automatic logic [c3cf_pkg::PIX_W-1:0] shift_in(logic [c3cf_pkg::PIX_W-1:0] p,
                                                          int unsigned h, int unsigned w);
    int unsigned                r;
    int unsigned                c;
    logic [c3cf_pkg::PIX_W-1:0] o;
    logic [c3cf_pkg::PIX_W-1:0] q;
    int                         i;
    int                         j;
    int                         pv;
    int                         wt;
    int                         sum;
    logic [c3cf_pkg::PIX_W-1:0] v;
    r = row_pos;
    c = col_pos;
    o = older_col[r];
    q = prev_col[r];
    older_col[r] = q;
    prev_col[r] = p;
    for (i = 0; i < 3; i++) begin
      win[0][i] = win[1][i];
      win[1][i] = win[2][i];
    end
    win[2][0] = o;
    win[2][1] = q;
    win[2][2] = p;
    v = win[1][1];
    if (c >= 2 && c + 1 <= w && r >= 2 && r + 1 <= h) begin
      sum = 0;
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3; j++) begin
          pv = win[i][j];
          wt = $signed(krow[i][8*j +: 8]);
          sum += pv * wt;
        end
      if (sum < 0) sum = 0;
      if (sum > c3cf_pkg::PIX_MAX) sum = c3cf_pkg::PIX_MAX;
      v = sum[c3cf_pkg::PIX_W-1:0];
    end
    if (row_pos + 1 >= h) begin
      row_pos = 0;
      col_pos = c + 1;
    end else begin
      row_pos = row_pos + 1;
    end
    return v;
  endfunction

  function automatic void apply_filter(logic cmd, logic [c3cf_pkg::PIX_W-1:0] pix);
    int unsigned                h;
    int unsigned                w;
    logic [c3cf_pkg::PIX_W-1:0] v;
    h = eff_rows();
    w = eff_cols();
    if (col_pos < w) begin
      if (cmd == c3cf_pkg::CMD_DRAIN) return;
      v = shift_in(pix, h, w);
      if (backlog >= h + 1) filtered_q.push_back('{v, 1'b0});
      else backlog++;
    end else if (backlog == 0) begin
      restart_frame_state();
    end else begin
      v = shift_in('0, h, w);
      backlog--;
      filtered_q.push_back('{v, backlog == 0});
      if (backlog == 0) restart_frame_state();
    end
  endfunction

  function automatic int unsigned pick_delay(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [c3cf_pkg::KROW_W-1:0] pick_kernel_row();
    logic [c3cf_pkg::KROW_W-1:0] row;
    int unsigned                 mode;
    int                          k;
    mode = $urandom_range(0, 2);
    for (k = 0; k < 3; k++) begin
      case (mode)
        0: row[8*k +: 8] = 8'($urandom);
        1: row[8*k +: 8] = 8'($urandom_range(0, 6) - 3);
        default: begin
          case ($urandom_range(0, 3))
            0: row[8*k +: 8] = 8'h7f;
            1: row[8*k +: 8] = 8'h80;
            2: row[8*k +: 8] = 8'h00;
            default: row[8*k +: 8] = 8'h01;
          endcase
        end
      endcase
    end
    return row;
  endfunction

  task automatic add_request(logic cmd, logic [c3cf_pkg::PIX_W-1:0] pix);
    request_q.push_back('{cmd, pix});
  endtask

  // one complete frame at the current size, optionally with ignored drains mixed in
  task automatic queue_frame(int unsigned lo, int unsigned hi, int unsigned noise_pct);
    int unsigned h;
    int unsigned w;
    int unsigned total;
    int unsigned flush;
    int unsigned k;
    h = eff_rows();
    w = eff_cols();
    total = h * w;
    flush = (total < h + 1) ? total : h + 1;
    for (k = 0; k < total; k++) begin
      if ($urandom_range(0, 99) < noise_pct) add_request(c3cf_pkg::CMD_DRAIN, 8'($urandom));
      add_request(c3cf_pkg::CMD_PUSH, 8'($urandom_range(lo, hi)));
    end
    for (k = 0; k < flush; k++)
      add_request(($urandom_range(0, 3) == 0) ? c3cf_pkg::CMD_PUSH : c3cf_pkg::CMD_DRAIN,
                  8'($urandom));
    if (noise_pct != 0 && $urandom_range(0, 3) == 0)
      add_request(c3cf_pkg::CMD_DRAIN, 8'($urandom));
    stream_items += total + flush;
  endtask

  task automatic write_reg(c3cf_pkg::reg_index_t idx, logic [c3cf_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      c3cf_pkg::REG_KERNEL_TOP: krow[0] = val;
      c3cf_pkg::REG_KERNEL_MID: krow[1] = val;
      c3cf_pkg::REG_KERNEL_BOT: krow[2] = val;
      c3cf_pkg::REG_HEIGHT:     height_reg = val[c3cf_pkg::HEIGHT_W-1:0];
      c3cf_pkg::REG_WIDTH:      width_reg = val[c3cf_pkg::WIDTH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (request_q.size() != 0 || pix_if.valid || filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_kernel();
    write_reg(c3cf_pkg::REG_KERNEL_TOP, pick_kernel_row());
    write_reg(c3cf_pkg::REG_KERNEL_MID, pick_kernel_row());
    write_reg(c3cf_pkg::REG_KERNEL_BOT, pick_kernel_row());
  endtask

  // request side
  always @(posedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
      feed_gap <= 0;
    end else begin
      if (pix_if.valid && pix_if.ready) apply_filter(pix_if.cmd, pix_if.pixel_in);
      if (!pix_if.valid || pix_if.ready) begin
        if (feed_gap != 0) begin
          pix_if.valid <= 1'b0;
          feed_gap <= feed_gap - 1;
        end else if (request_q.size() != 0) begin
          next_req = request_q.pop_front();
          pix_if.valid    <= 1'b1;
          pix_if.cmd      <= next_req.cmd;
          pix_if.pixel_in <= next_req.pixel;
          feed_gap <= pick_delay(feed_calm);
          if ($urandom_range(0, 99) == 0) feed_calm <= !feed_calm;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      take_hold <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result pixel_out %0d frame_last %0b", $time,
                   res_if.pixel_out, res_if.frame_last);
          mismatches++;
        end else begin
          want_res = filtered_q.pop_front();
          if (res_if.pixel_out !== want_res.pixel) begin
            $display("%0t: pixel_out expected %0d actual %0d", $time, want_res.pixel,
                     res_if.pixel_out);
            mismatches++;
          end
          if (res_if.frame_last !== want_res.last) begin
            $display("%0t: frame_last expected %0b actual %0b", $time, want_res.last,
                     res_if.frame_last);
            mismatches++;
          end
        end
      end
      if (take_hold != 0) begin
        res_if.ready <= 1'b0;
        take_hold <= take_hold - 1;
      end else begin
        res_if.ready <= 1'b1;
        take_hold <= pick_delay(take_calm);
        if ($urandom_range(0, 99) == 0) take_calm <= !take_calm;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned i;
    logic [c3cf_pkg::CFG_DATA_W-1:0] h_raw;
    logic [c3cf_pkg::CFG_DATA_W-1:0] w_raw;
    pix_if.valid    = 1'b0;
    pix_if.cmd      = c3cf_pkg::CMD_PUSH;
    pix_if.pixel_in = '0;
    res_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = c3cf_pkg::REG_KERNEL_TOP;
    cfg_if.data     = '0;
    mismatches   = 0;
    stream_items = 0;
    quiet_cycles = 0;
    feed_calm    = 1'b0;
    take_calm    = 1'b0;
    krow[0]    = '0;
    krow[1]    = c3cf_pkg::KROW_MID_RESET;
    krow[2]    = '0;
    height_reg = c3cf_pkg::HEIGHT_RESET;
    width_reg  = c3cf_pkg::WIDTH_RESET;
    for (i = 0; i < MAX_ROWS; i++) begin
      older_col[i] = '0;
      prev_col[i]  = '0;
    end
    restart_frame_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // saturation high: largest weights on a white 3x3
    write_reg(c3cf_pkg::REG_KERNEL_TOP, 24'h7f7f7f);
    write_reg(c3cf_pkg::REG_KERNEL_MID, 24'h7f7f7f);
    write_reg(c3cf_pkg::REG_KERNEL_BOT, 24'h7f7f7f);
    write_reg(c3cf_pkg::REG_HEIGHT, 24'd3);
    write_reg(c3cf_pkg::REG_WIDTH, 24'd3);
    queue_frame(255, 255, 0);
    settle();
    // saturation low: most negative weights
    write_reg(c3cf_pkg::REG_KERNEL_TOP, 24'h808080);
    write_reg(c3cf_pkg::REG_KERNEL_MID, 24'h808080);
    write_reg(c3cf_pkg::REG_KERNEL_BOT, 24'h808080);
    queue_frame(255, 255, 0);
    settle();
    // zero sizes act as 1x1: early drain ignored, late push acts as drain
    write_reg(c3cf_pkg::REG_HEIGHT, 24'd0);
    write_reg(c3cf_pkg::REG_WIDTH, 24'd0);
    add_request(c3cf_pkg::CMD_DRAIN, 8'h5a);
    add_request(c3cf_pkg::CMD_PUSH, 8'd255);
    add_request(c3cf_pkg::CMD_PUSH, 8'd0);
    add_request(c3cf_pkg::CMD_DRAIN, 8'h00);

    stream_items = 0;
    while (stream_items < RANDOM_ITEMS) begin
      settle();
      random_kernel();
      case ($urandom_range(0, 9))
        0: h_raw = 0;
        1: h_raw = $urandom_range(9, 24);
        default: h_raw = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: w_raw = 0;
        1: w_raw = $urandom_range(9, 20);
        default: w_raw = $urandom_range(1, 8);
      endcase
      write_reg(c3cf_pkg::REG_HEIGHT, h_raw);
      write_reg(c3cf_pkg::REG_WIDTH, w_raw);
      repeat ($urandom_range(1, 3)) queue_frame(0, 255, ($urandom_range(0, 3) == 0) ? 4 : 0);
    end
    settle();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
